### hdl/acg_pkg.sv
`default_nettype none

package acg_pkg;

    // Fixed register widths
    localparam int unsigned THR_W       = 15;
    localparam int unsigned GAIN_REG_W  = 25;
    localparam int unsigned LEN_W       = 16;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 25;

    // Register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REDUCED_GAIN    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_SAMPLES  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_SAMPLES = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_SAMPLES    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_STEP     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_STEP    = 3'd6;

    // Reset values
    localparam logic [THR_W-1:0]      RST_LEVEL_THRESHOLD = 15'd3000;
    localparam logic [GAIN_REG_W-1:0] RST_REDUCED_GAIN    = 25'd3355443;
    localparam logic [LEN_W-1:0]      RST_ATTACK_SAMPLES  = 16'd1440;
    localparam logic [LEN_W-1:0]      RST_RELEASE_SAMPLES = 16'd960;
    localparam logic [LEN_W-1:0]      RST_HOLD_SAMPLES    = 16'd480;
    localparam logic [GAIN_REG_W-1:0] RST_ATTACK_STEP     = 25'd9320;
    localparam logic [GAIN_REG_W-1:0] RST_RELEASE_STEP    = 25'd13981;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_ATTACK  = 2'd1,
        MODE_HOLD    = 2'd2,
        MODE_RELEASE = 2'd3
    } mode_t;

    typedef struct packed {
        logic [THR_W-1:0]      level_threshold;
        logic [GAIN_REG_W-1:0] reduced_gain;
        logic [LEN_W-1:0]      attack_samples;
        logic [LEN_W-1:0]      release_samples;
        logic [LEN_W-1:0]      hold_samples;
        logic [GAIN_REG_W-1:0] attack_step;
        logic [GAIN_REG_W-1:0] release_step;
    } cfg_regs_t;

endpackage

`default_nettype wire

### hdl/acg_cfg_regs.sv
`default_nettype none

module acg_cfg_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [acg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [acg_pkg::CFG_DATA_W-1:0]    cfg_data,
    output acg_pkg::cfg_regs_t                     regs
);

    acg_pkg::cfg_regs_t regs_reg;
    acg_pkg::cfg_regs_t regs_next;

    assign cfg_ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                acg_pkg::REG_LEVEL_THRESHOLD:
                    regs_next.level_threshold = cfg_data[acg_pkg::THR_W-1:0];
                acg_pkg::REG_REDUCED_GAIN:
                    regs_next.reduced_gain = cfg_data[acg_pkg::GAIN_REG_W-1:0];
                acg_pkg::REG_ATTACK_SAMPLES:
                    regs_next.attack_samples = cfg_data[acg_pkg::LEN_W-1:0];
                acg_pkg::REG_RELEASE_SAMPLES:
                    regs_next.release_samples = cfg_data[acg_pkg::LEN_W-1:0];
                acg_pkg::REG_HOLD_SAMPLES:
                    regs_next.hold_samples = cfg_data[acg_pkg::LEN_W-1:0];
                acg_pkg::REG_ATTACK_STEP:
                    regs_next.attack_step = cfg_data[acg_pkg::GAIN_REG_W-1:0];
                acg_pkg::REG_RELEASE_STEP:
                    regs_next.release_step = cfg_data[acg_pkg::GAIN_REG_W-1:0];
                default:
                    regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.level_threshold <= acg_pkg::RST_LEVEL_THRESHOLD;
            regs_reg.reduced_gain    <= acg_pkg::RST_REDUCED_GAIN;
            regs_reg.attack_samples  <= acg_pkg::RST_ATTACK_SAMPLES;
            regs_reg.release_samples <= acg_pkg::RST_RELEASE_SAMPLES;
            regs_reg.hold_samples    <= acg_pkg::RST_HOLD_SAMPLES;
            regs_reg.attack_step     <= acg_pkg::RST_ATTACK_STEP;
            regs_reg.release_step    <= acg_pkg::RST_RELEASE_STEP;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

### hdl/acg_envelope.sv
`default_nettype none

module acg_envelope #(
    parameter int unsigned SAMPLE_BITS    = 16,
    parameter int unsigned GAIN_FRAC_BITS = 24,
    parameter int unsigned COUNT_BITS     = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire acg_pkg::cfg_regs_t            regs,
    input  wire logic                          load,
    input  wire logic [SAMPLE_BITS-1:0]        sample,
    output logic [SAMPLE_BITS-1:0]             item_mag,
    output logic                               item_neg,
    output logic [GAIN_FRAC_BITS:0]            item_gain,
    output logic                               item_idle
);

    localparam int unsigned GW  = GAIN_FRAC_BITS + 1;
    localparam int unsigned EW  = (GW > acg_pkg::GAIN_REG_W ? GW : acg_pkg::GAIN_REG_W) + 1;
    localparam int unsigned TW  = SAMPLE_BITS > acg_pkg::THR_W ? SAMPLE_BITS : acg_pkg::THR_W;
    localparam int unsigned LXW = COUNT_BITS > acg_pkg::LEN_W ? COUNT_BITS : acg_pkg::LEN_W;

    acg_pkg::mode_t          mode_reg, mode_next;
    logic [COUNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [GW-1:0]           gain_reg, gain_next;

    logic [SAMPLE_BITS-1:0]  mag_reg;
    logic                    neg_reg;
    logic [GW-1:0]           item_gain_reg;
    logic                    idle_reg;

    logic                    neg;
    logic [SAMPLE_BITS-1:0]  mag;
    logic                    loud;
    logic                    quiet;
    logic [EW-1:0]           one_x;
    logic [EW-1:0]           gain_x;
    logic [EW-1:0]           rg_x;
    logic [EW-1:0]           floor_x;
    logic [EW-1:0]           atk_x;
    logic [EW-1:0]           rel_x;
    logic [EW-1:0]           sum_x;
    logic [LXW-1:0]          atk_len_x;
    logic [LXW-1:0]          rel_len_x;
    logic [LXW-1:0]          hold_len_x;
    logic [COUNT_BITS-1:0]   atk_len;
    logic [COUNT_BITS-1:0]   rel_len;
    logic [COUNT_BITS-1:0]   hold_len;

    // Magnitude of the most negative code wraps to 2^(SAMPLE_BITS-1), which fits unsigned
    assign neg   = sample[SAMPLE_BITS-1];
    assign mag   = neg ? (~sample + 1'b1) : sample;
    assign loud  = TW'(mag) > TW'(regs.level_threshold);
    assign quiet = TW'(mag) < TW'(regs.level_threshold);

    assign one_x   = EW'(1) << GAIN_FRAC_BITS;
    assign gain_x  = EW'(gain_reg);
    assign rg_x    = EW'(regs.reduced_gain);
    assign floor_x = (rg_x > one_x) ? one_x : rg_x;
    assign atk_x   = EW'(regs.attack_step);
    assign rel_x   = EW'(regs.release_step);
    assign sum_x   = gain_x + rel_x;

    assign atk_len_x  = LXW'(regs.attack_samples);
    assign rel_len_x  = LXW'(regs.release_samples);
    assign hold_len_x = LXW'(regs.hold_samples);
    assign atk_len    = atk_len_x[COUNT_BITS-1:0];
    assign rel_len    = rel_len_x[COUNT_BITS-1:0];
    assign hold_len   = hold_len_x[COUNT_BITS-1:0];

    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        gain_next = gain_reg;

        // Trigger rules act first, then the mode step
        if (loud)
        begin
            if (gain_x >= floor_x &&
                (mode_reg == acg_pkg::MODE_IDLE || mode_reg == acg_pkg::MODE_RELEASE))
            begin
                mode_next = acg_pkg::MODE_ATTACK;
                cnt_next  = atk_len;
            end
            if (mode_reg == acg_pkg::MODE_HOLD)
            begin
                cnt_next = hold_len;
            end
        end
        if (quiet && cnt_reg == '0 && mode_reg == acg_pkg::MODE_HOLD)
        begin
            mode_next = acg_pkg::MODE_RELEASE;
            cnt_next  = rel_len;
        end

        case (mode_next)
            acg_pkg::MODE_ATTACK:
            begin
                if (cnt_next != '0 && gain_x > floor_x)
                begin
                    gain_next = (atk_x >= gain_x) ? '0 : GW'(gain_x - atk_x);
                    cnt_next  = cnt_next - 1'b1;
                end
                else
                begin
                    mode_next = acg_pkg::MODE_HOLD;
                    cnt_next  = hold_len;
                end
            end
            acg_pkg::MODE_HOLD:
            begin
                if (cnt_next != '0)
                begin
                    cnt_next = cnt_next - 1'b1;
                end
                else
                begin
                    mode_next = acg_pkg::MODE_RELEASE;
                    cnt_next  = rel_len;
                end
            end
            acg_pkg::MODE_RELEASE:
            begin
                if (cnt_next != '0 && gain_x < one_x)
                begin
                    cnt_next  = cnt_next - 1'b1;
                    gain_next = (sum_x > one_x) ? GW'(one_x) : GW'(sum_x);
                end
                else
                begin
                    mode_next = acg_pkg::MODE_IDLE;
                end
            end
            default:
            begin
                gain_next = GW'(one_x);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= acg_pkg::MODE_IDLE;
            cnt_reg  <= '0;
            gain_reg <= GW'(one_x);
        end
        else if (load)
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            gain_reg <= gain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mag_reg       <= mag;
            neg_reg       <= neg;
            item_gain_reg <= gain_next;
            idle_reg      <= (mode_next == acg_pkg::MODE_IDLE);
        end
    end

    assign item_mag  = mag_reg;
    assign item_neg  = neg_reg;
    assign item_gain = item_gain_reg;
    assign item_idle = idle_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg <= GW'(one_x))
        else $error("gain above unity");

    assert property (@(posedge clk) disable iff (!rst_n)
        load && mode_reg == acg_pkg::MODE_IDLE && !loud |=> mode_reg == acg_pkg::MODE_IDLE)
        else $error("left idle without a loud sample");

    assert property (@(posedge clk) disable iff (!rst_n)
        load && mode_reg == acg_pkg::MODE_IDLE && !loud |=> gain_reg == GW'(one_x))
        else $error("idle step did not restore unity gain");

    assert property (@(posedge clk) disable iff (!rst_n)
        load |=> item_idle == (mode_reg == acg_pkg::MODE_IDLE))
        else $error("idle flag disagrees with mode");

endmodule

`default_nettype wire

### hdl/acg_gain_apply.sv
`default_nettype none

module acg_gain_apply #(
    parameter int unsigned SAMPLE_BITS    = 16,
    parameter int unsigned GAIN_FRAC_BITS = 24
) (
    input  wire logic                      clk,
    input  wire logic                      load,
    input  wire logic [SAMPLE_BITS-1:0]    mag,
    input  wire logic                      neg,
    input  wire logic [GAIN_FRAC_BITS:0]   gain,
    input  wire logic                      idle,
    output logic [SAMPLE_BITS-1:0]         sample_out,
    output logic                           is_idle
);

    localparam int unsigned GW = GAIN_FRAC_BITS + 1;
    localparam int unsigned PW = SAMPLE_BITS + GW;
    localparam int unsigned QW = PW - GAIN_FRAC_BITS;

    logic [PW-1:0]          prod;
    logic [PW-1:0]          rnd;
    logic [QW-1:0]          q;
    logic [QW-1:0]          limit;
    logic [QW-1:0]          q_sat;
    logic [SAMPLE_BITS-1:0] result;

    logic [SAMPLE_BITS-1:0] sample_out_reg;
    logic                   is_idle_reg;

    // Round half away from zero: rounding is done on the magnitude
    assign prod   = PW'(mag) * PW'(gain);
    assign rnd    = prod + (PW'(1) << (GAIN_FRAC_BITS - 1));
    assign q      = rnd[PW-1:GAIN_FRAC_BITS];
    assign limit  = neg ? (QW'(1) << (SAMPLE_BITS - 1))
                        : ((QW'(1) << (SAMPLE_BITS - 1)) - 1'b1);
    assign q_sat  = (q > limit) ? limit : q;
    assign result = neg ? (~q_sat[SAMPLE_BITS-1:0] + 1'b1) : q_sat[SAMPLE_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sample_out_reg <= result;
            is_idle_reg    <= idle;
        end
    end

    assign sample_out = sample_out_reg;
    assign is_idle    = is_idle_reg;

    assert property (@(posedge clk)
        load && !neg |=> !sample_out_reg[SAMPLE_BITS-1])
        else $error("positive input gave negative output");

    assert property (@(posedge clk)
        load && mag == '0 |=> sample_out_reg == '0)
        else $error("zero input gave nonzero output");

    assert property (@(posedge clk)
        load && gain == '0 |=> sample_out_reg == '0)
        else $error("zero gain gave nonzero output");

endmodule

`default_nettype wire

### hdl/audio_compressor_gain_envelope_top.sv
// Compressor gain envelope: each input sample updates an idle/attack/hold/release
// mode, a down-counter and a Q1.GAIN_FRAC_BITS gain, and the block returns the sample
// times the updated gain (rounded half away from zero, saturated) with an idle flag in
// tuser. One sample is taken every clock cycle unless m_axis_tready back-pressure fills both
// stages. The rate is set by the envelope state update, whose result is registered in a first
// stage; the multiply, round and saturate follow in a second register stage. Configuration
// writes are always taken (cfg_ready is high) and should be issued while the stream is idle.
`default_nettype none

module audio_compressor_gain_envelope_top #(
    parameter int unsigned SAMPLE_BITS    = 16,
    parameter int unsigned GAIN_FRAC_BITS = 24,
    parameter int unsigned COUNT_BITS     = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // sample_in
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // sample_out
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]           m_axis_tdata,
    // is_idle
    output logic                                       m_axis_tuser,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [acg_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [acg_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int unsigned DW = ((SAMPLE_BITS + 7) / 8) * 8;

    acg_pkg::cfg_regs_t          regs;
    logic                        s1_valid_reg, s1_valid_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_en;
    logic                        s1_ready;
    logic                        accept;
    logic [SAMPLE_BITS-1:0]      s1_mag;
    logic                        s1_neg;
    logic [GAIN_FRAC_BITS:0]     s1_gain;
    logic                        s1_idle;
    logic [SAMPLE_BITS-1:0]      sample_out;
    logic                        is_idle;

    // Each stage moves when the one after it is empty or moving
    assign out_en        = !out_valid_reg || m_axis_tready;
    assign s1_ready      = !s1_valid_reg || out_en;
    assign s_axis_tready = s1_ready;
    assign accept        = s_axis_tvalid && s1_ready;

    always_comb
    begin
        s1_valid_next  = s1_ready ? s_axis_tvalid : s1_valid_reg;
        out_valid_next = out_en ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    acg_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (regs)
    );

    acg_envelope #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .COUNT_BITS     (COUNT_BITS)
    ) u_env (
        .clk       (clk),
        .rst_n     (rst_n),
        .regs      (regs),
        .load      (accept),
        .sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
        .item_mag  (s1_mag),
        .item_neg  (s1_neg),
        .item_gain (s1_gain),
        .item_idle (s1_idle)
    );

    acg_gain_apply #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_apply (
        .clk        (clk),
        .load       (out_en && s1_valid_reg),
        .mag        (s1_mag),
        .neg        (s1_neg),
        .gain       (s1_gain),
        .idle       (s1_idle),
        .sample_out (sample_out),
        .is_idle    (is_idle)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = DW'(sample_out);
    assign m_axis_tuser  = is_idle;

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_en |=> s1_valid_reg)
        else $error("stalled item dropped from first stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled output changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_en |=> out_valid_reg)
        else $error("item lost between stages");

endmodule

`default_nettype wire
